>>> sv/rsh_pkg.sv
package rsh_pkg;

    localparam int SHELLS_DEF = 64;

    localparam logic [23:0] CNT_MAX = 24'hFF_FFFF;
    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    localparam logic [31:0] SHELL_WIDTH_RST   = 32'd65537;
    localparam logic [6:0]  SHELLS_IN_USE_RST = 7'd64;

    // One root bit is produced per step of the square root.
    localparam logic [5:0] SQRT_LAST_STEP = 6'd33;
    localparam logic [1:0] AXIS_LAST      = 2'd2;

    typedef enum logic [2:0] {
        REG_SHELL_WIDTH   = 3'd0,
        REG_SHELLS_IN_USE = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_ORIGIN_Z      = 3'd4
    } rsh_reg_t;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         contacts;
    } rsh_in_t;

    typedef struct packed {
        logic [5:0]  shell_index;
        logic [23:0] shell_count;
        logic [15:0] shell_avg_contacts;
        logic [23:0] inner_count;
        logic [15:0] inner_avg_contacts;
        logic        last;
    } rsh_out_t;

    typedef enum logic [1:0] {
        DIV_IDX   = 2'd0,
        DIV_SHELL = 2'd1,
        DIV_INNER = 2'd2
    } rsh_div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_DIFF,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_IDX_START,
        ST_IDX_DIV,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_FIN_RD,
        ST_FIN_ACC,
        ST_AVG_SHELL,
        ST_AVG_INNER,
        ST_CLEAR
    } rsh_state_t;

    typedef struct packed {
        logic         capture;
        logic [1:0]   axis;
        logic         diff_ld;
        logic         mul_ld;
        logic         acc_add;
        logic         sqrt_init;
        logic         sqrt_step;
        logic         div_start;
        rsh_div_sel_t div_sel;
        logic         rd_en;
        logic         rd_fin;
        logic         wr_en;
        logic         fin_acc;
        logic         cap_shell;
        logic         emit;
        logic         k_inc;
        logic         clear;
    } rsh_cmd_t;

    typedef struct packed {
        logic div_done;
        logic drop;
        logic k_last;
    } rsh_sts_t;

endpackage

>>> sv/rsh_div.sv
module rsh_div
    import rsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        short_q,
    input  logic [47:0] num,
    input  logic [31:0] den,
    output logic [15:0] quo,
    output logic        ovf,
    output logic        done
);

    localparam logic [4:0] QB_SHORT = 5'd7;
    localparam logic [4:0] QB_LONG  = 5'd16;

    logic        run_reg, run_next;
    logic        first_reg, first_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] dsh_reg, dsh_next;
    logic [15:0] quo_reg, quo_next;
    logic        ovf_reg, ovf_next;
    logic        ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        run_next   = run_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        ovf_next   = ovf_reg;
        if (start)
        begin
            run_next   = 1'b1;
            first_next = 1'b1;
            rem_next   = num;
            dsh_next   = short_q ? {9'd0, den, 7'd0} : {den, 16'd0};
            cnt_next   = short_q ? QB_SHORT : QB_LONG;
            quo_next   = '0;
        end
        else if (run_reg && first_reg)
        begin
            // The quotient overflows its width when num reaches den shifted by the width.
            ovf_next   = ge;
            first_next = 1'b0;
            dsh_next   = dsh_reg >> 1;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[14:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        ovf_reg   <= ovf_next;
    end

    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

>>> sv/rsh_ctrl.sv
module rsh_ctrl
    import rsh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     mode,
    input  rsh_sts_t sts,
    output rsh_cmd_t cmd,
    output logic     busy
);

    rsh_state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic [5:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    state_next  = mode ? ST_FIN_RD : ST_SQ_DIFF;
                end
            end
            ST_SQ_DIFF:
            begin
                cmd.diff_ld = 1'b1;
                state_next  = ST_SQ_MUL;
            end
            ST_SQ_MUL:
            begin
                cmd.mul_ld = 1'b1;
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (axis_reg == AXIS_LAST)
                begin
                    state_next = ST_SQRT_INIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQ_DIFF;
                end
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 6'd1;
                if (step_reg == SQRT_LAST_STEP)
                begin
                    state_next = ST_IDX_START;
                end
            end
            ST_IDX_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_IDX;
                state_next    = ST_IDX_DIV;
            end
            ST_IDX_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                if (sts.drop)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_UPD_WR;
                end
            end
            ST_UPD_WR:
            begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIN_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_fin = 1'b1;
                state_next = ST_FIN_ACC;
            end
            ST_FIN_ACC:
            begin
                cmd.fin_acc   = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SHELL;
                state_next    = ST_AVG_SHELL;
            end
            ST_AVG_SHELL:
            begin
                cmd.div_sel = DIV_INNER;
                if (sts.div_done)
                begin
                    cmd.cap_shell = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_AVG_INNER;
                end
            end
            ST_AVG_INNER:
            begin
                if (sts.div_done)
                begin
                    cmd.emit = 1'b1;
                    if (sts.k_last)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_FIN_RD;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> sv/rsh_datapath.sv
module rsh_datapath
    import rsh_pkg::*;
#(
    parameter int SHELLS = SHELLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rsh_in_t            item,
    input  logic [31:0]        shell_width,
    input  logic [6:0]         shells_in_use,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  rsh_cmd_t           cmd,
    output rsh_sts_t           sts,
    output logic               result_valid,
    output rsh_out_t           result
);

    // Only the first 127 shells can ever be addressed through the 7-bit register.
    localparam int MEM_DEPTH = (SHELLS < 128) ? SHELLS : 128;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [7:0] N_CAP = (SHELLS > 127) ? 8'd127 : 8'(SHELLS);

    rsh_in_t     item_reg;
    logic [6:0]  n_eff;
    logic [31:0] pos_sel, org_sel;
    logic [32:0] diff, diff_abs;
    logic [31:0] absd_reg;
    logic [63:0] prod_reg;
    logic [65:0] acc_reg;
    logic [67:0] op_reg;
    logic [36:0] rem_reg;
    logic [33:0] root_reg;
    logic [36:0] rem_sh, trial;
    logic        root_ge;

    logic        div_start, div_short, div_done, div_ovf;
    logic [47:0] div_num;
    logic [31:0] div_den, w_eff;
    logic [15:0] div_quo;

    logic [55:0] mem [MEM_DEPTH];
    logic [55:0] rd_data_reg;
    logic        rd_valid_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [AW-1:0] rd_addr, wr_addr_reg;
    logic [23:0] rd_cnt, cnt_new;
    logic [31:0] rd_sum, sum_new;
    logic [32:0] sum_add;

    logic [6:0]  k_reg;
    logic [24:0] icnt_add;
    logic [23:0] icnt_reg;
    logic [39:0] isum_reg;
    logic [15:0] shell_avg_reg, inner_avg;
    logic        result_valid_reg;
    rsh_out_t    result_reg;

    assign n_eff = (shells_in_use == 7'd0) ? 7'd1
                 : (({1'b0, shells_in_use} > N_CAP) ? N_CAP[6:0] : shells_in_use);

    always_comb
    begin
        unique case (cmd.axis)
            2'd0:
            begin
                pos_sel = item_reg.pos_x;
                org_sel = origin_x;
            end
            2'd1:
            begin
                pos_sel = item_reg.pos_y;
                org_sel = origin_y;
            end
            default:
            begin
                pos_sel = item_reg.pos_z;
                org_sel = origin_z;
            end
        endcase
    end

    assign diff     = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
    assign diff_abs = diff[32] ? (33'd0 - diff) : diff;

    // Digit-by-digit square root, one root bit per step.
    assign rem_sh  = {rem_reg[34:0], op_reg[67:66]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign root_ge = (rem_sh >= trial);

    assign w_eff = (shell_width == 32'd0) ? 32'd1 : shell_width;

    always_comb
    begin
        div_short = 1'b0;
        unique case (cmd.div_sel)
            DIV_IDX:
            begin
                div_num   = {14'd0, root_reg};
                div_den   = w_eff;
                div_short = 1'b1;
            end
            DIV_SHELL:
            begin
                div_num = {8'd0, rd_sum, 8'd0};
                div_den = {8'd0, rd_cnt};
            end
            default:
            begin
                div_num = {isum_reg, 8'd0};
                div_den = {8'd0, icnt_reg};
            end
        endcase
    end

    assign div_start = cmd.div_start;

    rsh_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .short_q (div_short),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .ovf     (div_ovf),
        .done    (div_done)
    );

    assign rd_addr = cmd.rd_fin ? k_reg[AW-1:0] : div_quo[AW-1:0];
    assign rd_cnt  = rd_valid_reg ? rd_data_reg[55:32] : 24'd0;
    assign rd_sum  = rd_valid_reg ? rd_data_reg[31:0] : 32'd0;
    assign cnt_new = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 24'd1;
    assign sum_add = {1'b0, rd_sum} + {25'd0, item_reg.contacts};
    assign sum_new = sum_add[32] ? SUM_MAX : sum_add[31:0];

    assign icnt_add  = {1'b0, icnt_reg} + {1'b0, rd_cnt};
    assign inner_avg = (icnt_reg == 24'd0) ? 16'd0 : (div_ovf ? 16'hFFFF : div_quo);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
            acc_reg  <= '0;
            icnt_reg <= '0;
            isum_reg <= '0;
        end
        if (cmd.diff_ld)
        begin
            absd_reg <= diff_abs[31:0];
        end
        if (cmd.mul_ld)
        begin
            prod_reg <= absd_reg * absd_reg;
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + {2'd0, prod_reg};
        end
        if (cmd.sqrt_init)
        begin
            op_reg   <= {2'd0, acc_reg};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            op_reg   <= {op_reg[65:0], 2'd0};
            rem_reg  <= root_ge ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[32:0], root_ge};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            wr_addr_reg <= rd_addr;
        end
        if (cmd.wr_en)
        begin
            mem[wr_addr_reg] <= {cnt_new, sum_new};
        end
        if (cmd.fin_acc)
        begin
            icnt_reg <= icnt_add[24] ? CNT_MAX : icnt_add[23:0];
            isum_reg <= isum_reg + {8'd0, rd_sum};
        end
        if (cmd.cap_shell)
        begin
            shell_avg_reg <= (rd_cnt == 24'd0) ? 16'd0 : (div_ovf ? 16'hFFFF : div_quo);
        end
        if (cmd.emit)
        begin
            result_reg.shell_index        <= k_reg[5:0];
            result_reg.shell_count        <= rd_cnt;
            result_reg.shell_avg_contacts <= shell_avg_reg;
            result_reg.inner_count        <= icnt_reg;
            result_reg.inner_avg_contacts <= inner_avg;
            result_reg.last               <= sts.k_last;
        end
    end

    // An entry not written since the last finish reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit;
            if (cmd.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (cmd.clear)
            begin
                valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (cmd.capture)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_inc)
            begin
                k_reg <= k_reg + 7'd1;
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.drop     = div_ovf || (div_quo[6:0] >= n_eff);
    assign sts.k_last   = (k_reg == (n_eff - 7'd1));

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> sv/radial_shell_histogram.sv
// Particle item: squared distance on one shared multiplier, bit-per-step square root,
// then the shell index divider.
// Finish item: two 17-step average divisions for each shell in use, then the valid
// bits are cleared; results are one-cycle strobes, no back-pressure.
// One item at a time; start is taken only while busy is low.
// rst_n clears the controller, the registers to their defaults and the valid bits of all shell entries.
module radial_shell_histogram
    import rsh_pkg::*;
#(
    parameter int SHELLS = SHELLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  rsh_in_t     item,
    output logic        result_valid,
    output rsh_out_t    result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]        shell_width_reg;
    logic [6:0]         shells_in_use_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic               cfg_wr;
    rsh_cmd_t           cmd;
    rsh_sts_t           sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shell_width_reg   <= SHELL_WIDTH_RST;
            shells_in_use_reg <= SHELLS_IN_USE_RST;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            origin_z_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_SHELL_WIDTH:   shell_width_reg   <= pwdata;
                REG_SHELLS_IN_USE: shells_in_use_reg <= pwdata[6:0];
                REG_ORIGIN_X:      origin_x_reg      <= pwdata;
                REG_ORIGIN_Y:      origin_y_reg      <= pwdata;
                REG_ORIGIN_Z:      origin_z_reg      <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_SHELL_WIDTH:   prdata = shell_width_reg;
            REG_SHELLS_IN_USE: prdata = {25'd0, shells_in_use_reg};
            REG_ORIGIN_X:      prdata = origin_x_reg;
            REG_ORIGIN_Y:      prdata = origin_y_reg;
            REG_ORIGIN_Z:      prdata = origin_z_reg;
            default:           prdata = '0;
        endcase
    end

    rsh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (item.mode),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    rsh_datapath #(
        .SHELLS (SHELLS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .shell_width   (shell_width_reg),
        .shells_in_use (shells_in_use_reg),
        .origin_x      (origin_x_reg),
        .origin_y      (origin_y_reg),
        .origin_z      (origin_z_reg),
        .cmd           (cmd),
        .sts           (sts),
        .result_valid  (result_valid),
        .result        (result)
    );

endmodule

>>> sv/rsh_checker.sv
module rsh_checker
    import rsh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input rsh_in_t  item,
    input logic     result_valid,
    input rsh_out_t result
);

    // Results only appear while a finish transfer is still being worked on.
    assert property (@(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("result strobe while idle");

    // A particle transfer never produces a result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.mode) |=> (busy && !result_valid))
        else $error("particle transfer not taken correctly");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |=> !result_valid)
        else $error("result after the last shell");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |=> (busy && !result_valid))
        else $error("run ended before the last shell");

endmodule

bind radial_shell_histogram rsh_checker u_rsh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);
